// File: hdl/ptvm_pkg.sv
`timescale 1ns / 1ps

package ptvm_pkg;

    // default voice count
    localparam int unsigned VOICES_DEF = 128;

    // fixed field widths
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned KEY_W      = 7;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned COUNT_O_W  = 8;
    localparam int unsigned PHASE_W    = 32;

    typedef logic [CMD_W-1:0]           t_cmd;
    typedef logic [KEY_W-1:0]           t_key;
    typedef logic [PHASE_W-1:0]         t_phase;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [STATUS_W-1:0]        t_status;
    typedef logic [COUNT_O_W-1:0]       t_count_o;

    // request commands
    localparam t_cmd CMD_TICK     = 2'd0;
    localparam t_cmd CMD_NOTE_ON  = 2'd1;
    localparam t_cmd CMD_NOTE_OFF = 2'd2;
    localparam t_cmd CMD_UNUSED   = 2'd3;

    // result status codes
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_FREE  = 2'd1;
    localparam t_status ST_NO_MATCH = 2'd2;

    // one voice record in the voice memory
    typedef struct packed {
        t_key   key;
        t_phase inc;
        t_phase phase;
    } t_voice;

    // phase increment = round(f * 2^32 / 44100), f in units of 1e-4 Hz
    localparam logic [63:0] PHASE_ONE   = 64'd4294967296;
    localparam logic [63:0] RATE_SCALED = 64'd441000000;
    localparam logic [63:0] RATE_HALF   = 64'd220500000;

    // octave 5 increments, C up to B, unused pitch classes read zero
    localparam t_phase PITCH_INC [16] = '{
        32'((64'd2616256 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd2771826 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd2936648 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd3111270 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd3296276 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd3492282 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd3699944 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd3919954 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd4153047 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd4400000 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd4661638 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'((64'd4938833 * PHASE_ONE + RATE_HALF) / RATE_SCALED),
        32'd0, 32'd0, 32'd0, 32'd0
    };

    localparam logic [3:0] BASE_OCTAVE = 4'd5;

    // key to phase increment: octave = key / 12 via key * 43 >> 9 (exact for 0..127)
    function automatic t_phase key_increment(input t_key key);
        logic [12:0] prod;
        logic [3:0]  oct;
        logic [6:0]  oct12;
        logic [3:0]  pc;
        t_phase      base;
        begin
            prod  = 13'(key) * 13'd43;
            oct   = prod[12:9];
            oct12 = 7'(oct) * 7'd12;
            pc    = 4'(key - oct12);
            base  = PITCH_INC[pc];
            if (oct >= BASE_OCTAVE) begin
                key_increment = base << 3'(oct - BASE_OCTAVE);
            end else begin
                key_increment = base >> 3'(BASE_OCTAVE - oct);
            end
        end
    endfunction

    // triangle starting at -1: rises over the first half period, falls over the second
    function automatic t_sample triangle(input t_phase phase);
        logic [16:0] u;
        begin
            u = phase[31:15];
            if (!u[16]) begin
                triangle = {~u[15], u[14:0]};
            end else begin
                triangle = {u[15], ~u[14:0]};
            end
        end
    endfunction

endpackage

// File: hdl/ptvm_if.sv
`timescale 1ns / 1ps

// request channel
interface ptvm_in_if;
    import ptvm_pkg::*;

    logic valid;
    logic ready;
    t_cmd command;
    t_key note;

    modport source (output valid, output command, output note, input ready);
    modport sink   (input valid, input command, input note, output ready);
endinterface

// result channel
interface ptvm_out_if;
    import ptvm_pkg::*;

    logic     valid;
    logic     ready;
    t_sample  sample;
    t_status  status;
    t_count_o active_voices;

    modport source (output valid, output sample, output status, output active_voices,
                    input ready);
    modport sink   (input valid, input sample, input status, input active_voices,
                    output ready);
endinterface

// File: hdl/ptvm_voice_ram.sv
`timescale 1ns / 1ps

module ptvm_voice_ram #(
    parameter int unsigned VOICES = ptvm_pkg::VOICES_DEF,
    parameter int unsigned VW     = 7
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [VW-1:0]    i_rd_addr,
    output ptvm_pkg::t_voice o_rd_data,
    input  logic             i_wr_en,
    input  logic [VW-1:0]    i_wr_addr,
    input  ptvm_pkg::t_voice i_wr_data
);
    import ptvm_pkg::*;

    t_voice r_mem [VOICES];
    t_voice r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/ptvm_free_stack.sv
`timescale 1ns / 1ps

module ptvm_free_stack #(
    parameter int unsigned VOICES = ptvm_pkg::VOICES_DEF,
    parameter int unsigned VW     = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [VW-1:0] i_rd_addr,
    output logic [VW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [VW-1:0] i_wr_addr,
    input  logic [VW-1:0] i_wr_data
);
    logic [VW-1:0]     r_mem [VOICES];
    logic [VOICES-1:0] r_written;
    logic [VW-1:0]     r_rd_raw;
    logic [VW-1:0]     r_rd_addr;
    logic              r_rd_hit;

    // stack storage with registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw  <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // per-entry written flags, an unwritten entry holds its reset voice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_written[i_rd_addr];
            end
        end
    end

    // entry i starts out as voice VOICES-1-i
    assign o_rd_data = r_rd_hit ? r_rd_raw : VW'(VOICES - 1) - r_rd_addr;

endmodule

// File: hdl/ptvm_div.sv
`timescale 1ns / 1ps

module ptvm_div #(
    parameter int unsigned SUMW = 23,
    parameter int unsigned CW   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [SUMW-1:0] i_dividend,
    input  logic [CW-1:0]          i_divisor,
    output logic                   o_done,
    output ptvm_pkg::t_sample      o_quotient
);
    import ptvm_pkg::*;

    localparam int unsigned NW = $clog2(SUMW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_rem, n_rem;
    logic [SUMW-1:0] r_quo, n_quo;
    logic [CW-1:0]   r_den, n_den;
    logic            r_neg, n_neg;
    logic [CW:0]     trial;
    t_sample         q_mag;

    // restoring division on the magnitude, one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        trial  = {r_rem, r_quo[SUMW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = NW'(SUMW);
            n_rem  = '0;
            n_den  = i_divisor;
            n_neg  = i_dividend[SUMW-1];
            n_quo  = i_dividend[SUMW-1] ? SUMW'(-i_dividend) : SUMW'(i_dividend);
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = CW'(trial - {1'b0, r_den});
                n_quo = {r_quo[SUMW-2:0], 1'b1};
            end else begin
                n_rem = CW'(trial);
                n_quo = {r_quo[SUMW-2:0], 1'b0};
            end
            n_cnt = r_cnt - NW'(1);
            if (r_cnt == NW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    assign q_mag      = t_sample'(r_quo[SAMPLE_W-1:0]);
    assign o_quotient = r_neg ? -q_mag : q_mag;
    assign o_done     = r_done;

endmodule

// File: hdl/polyphonic_triangle_voice_mixer.sv
`timescale 1ns / 1ps

// Polyphonic triangle voice mixer. Requests are note on, note off and sample tick; each
// request gives exactly one result with the mixed Q1.15 sample (ticks only), a status and
// the number of sounding voices afterwards. Voice records (key, increment, phase) live in
// one single-port-read memory and free voices in a stack memory; no clearing pass is
// needed after reset. One request is worked at a time and the next is taken while the
// previous result waits on the output. A tick walks every voice through the voice memory
// read port, one voice per cycle, then divides the sum by the sounding count in a
// bit-serial divider. A note on pops a free voice off the stack and loads its record.
// A note off scans the voice memory from voice 0 until the first sounding voice holding
// the key. Ticks and note offs with no sounding voice, note ons with no free voice and
// the unused command go straight from dispatch to the result hand-off.
module polyphonic_triangle_voice_mixer #(
    parameter int unsigned VOICES = ptvm_pkg::VOICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptvm_in_if.sink           i_cmd,
    ptvm_out_if.source        o_res
);
    import ptvm_pkg::*;

    localparam int unsigned VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int unsigned CW   = $clog2(VOICES + 1);
    localparam int unsigned SUMW = SAMPLE_W + VW;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_ON_WR  = 3'd3;
    localparam logic [2:0] S_OFF    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            r_state, n_state;
    t_key                  r_key, n_key;
    t_phase                r_inc, n_inc;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_p_valid, n_p_valid;
    logic [VW-1:0]         r_p_voice, n_p_voice;
    logic signed [SUMW-1:0] r_sum, n_sum;
    logic [VOICES-1:0]     r_active, n_active;
    logic [CW-1:0]         r_free_cnt, n_free_cnt;
    logic [CW-1:0]         r_snd_cnt, n_snd_cnt;
    t_sample               r_res_sample, n_res_sample;
    t_status               r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    t_sample               r_out_sample, n_out_sample;
    t_status               r_out_status, n_out_status;
    t_count_o              r_out_count, n_out_count;

    logic                  accept;
    logic                  out_free;
    logic [CW-1:0]         free_top;

    logic                  vr_rd_en, vr_wr_en;
    logic [VW-1:0]         vr_rd_addr, vr_wr_addr;
    t_voice                vr_rd_data, vr_wr_data;
    logic                  fs_rd_en, fs_wr_en;
    logic [VW-1:0]         fs_rd_addr, fs_wr_addr, fs_wr_data, fs_rd_data;
    logic                  div_start, div_done;
    t_sample               div_quotient;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;
    assign free_top    = r_free_cnt - CW'(1);

    ptvm_voice_ram #(.VOICES(VOICES), .VW(VW)) u_voice_ram (
        .i_clk     (i_clk),
        .i_rd_en   (vr_rd_en),
        .i_rd_addr (vr_rd_addr),
        .o_rd_data (vr_rd_data),
        .i_wr_en   (vr_wr_en),
        .i_wr_addr (vr_wr_addr),
        .i_wr_data (vr_wr_data)
    );

    ptvm_free_stack #(.VOICES(VOICES), .VW(VW)) u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (fs_rd_en),
        .i_rd_addr (fs_rd_addr),
        .o_rd_data (fs_rd_data),
        .i_wr_en   (fs_wr_en),
        .i_wr_addr (fs_wr_addr),
        .i_wr_data (fs_wr_data)
    );

    ptvm_div #(.SUMW(SUMW), .CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_snd_cnt),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // sequencer: voice walks read one entry per cycle; the tick walk writes back the entry
    // read in the previous cycle, so a read never meets a pending write to the same voice
    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_inc        = r_inc;
        n_idx        = r_idx;
        n_p_valid    = 1'b0;
        n_p_voice    = r_p_voice;
        n_sum        = r_sum;
        n_active     = r_active;
        n_free_cnt   = r_free_cnt;
        n_snd_cnt    = r_snd_cnt;
        n_res_sample = r_res_sample;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_sample = r_out_sample;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        vr_rd_en     = 1'b0;
        vr_rd_addr   = r_idx[VW-1:0];
        vr_wr_en     = 1'b0;
        vr_wr_addr   = r_p_voice;
        vr_wr_data   = vr_rd_data;
        fs_rd_en     = 1'b0;
        fs_rd_addr   = free_top[VW-1:0];
        fs_wr_en     = 1'b0;
        fs_wr_addr   = r_free_cnt[VW-1:0];
        fs_wr_data   = r_p_voice;
        div_start    = 1'b0;

        unique case (r_state)
            // take a request and dispatch
            S_IDLE: begin
                if (accept) begin
                    n_key        = i_cmd.note;
                    n_inc        = key_increment(i_cmd.note);
                    n_idx        = '0;
                    n_sum        = '0;
                    n_res_sample = '0;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                    unique case (i_cmd.command)
                        CMD_TICK: begin
                            if (r_snd_cnt != '0) begin
                                n_state = S_TICK;
                            end
                        end
                        CMD_NOTE_ON: begin
                            if (r_free_cnt == '0) begin
                                n_res_status = ST_NO_FREE;
                            end else begin
                                fs_rd_en   = 1'b1;
                                n_free_cnt = free_top;
                                n_state    = S_ON_WR;
                            end
                        end
                        CMD_NOTE_OFF: begin
                            if (r_snd_cnt == '0) begin
                                n_res_status = ST_NO_MATCH;
                            end else begin
                                n_state = S_OFF;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // walk all voices: accumulate triangle, advance phase of each sounding voice
            S_TICK: begin
                if (r_idx != CW'(VOICES)) begin
                    vr_rd_en  = 1'b1;
                    n_idx     = r_idx + CW'(1);
                    n_p_valid = 1'b1;
                    n_p_voice = r_idx[VW-1:0];
                end
                if (r_p_valid && r_active[r_p_voice]) begin
                    n_sum = r_sum + SUMW'(triangle(vr_rd_data.phase));
                    vr_wr_en         = 1'b1;
                    vr_wr_data.phase = vr_rd_data.phase + vr_rd_data.inc;
                end
                if (r_idx == CW'(VOICES) && !r_p_valid) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end

            // wait on the mix divider
            S_DIV: begin
                if (div_done) begin
                    n_res_sample = div_quotient;
                    n_state      = S_DONE;
                end
            end

            // popped voice arrives: load its record and mark it sounding
            S_ON_WR: begin
                vr_wr_en         = 1'b1;
                vr_wr_addr       = fs_rd_data;
                vr_wr_data.key   = r_key;
                vr_wr_data.inc   = r_inc;
                vr_wr_data.phase = '0;
                n_active[fs_rd_data] = 1'b1;
                n_snd_cnt        = r_snd_cnt + CW'(1);
                n_state          = S_DONE;
            end

            // search for the lowest sounding voice with the key
            S_OFF: begin
                if (r_p_valid && r_active[r_p_voice] && vr_rd_data.key == r_key) begin
                    n_active[r_p_voice] = 1'b0;
                    fs_wr_en   = 1'b1;
                    n_free_cnt = r_free_cnt + CW'(1);
                    n_snd_cnt  = r_snd_cnt - CW'(1);
                    n_state    = S_DONE;
                end else if (r_idx == CW'(VOICES) && !r_p_valid) begin
                    n_res_status = ST_NO_MATCH;
                    n_state      = S_DONE;
                end else if (r_idx != CW'(VOICES)) begin
                    vr_rd_en  = 1'b1;
                    n_idx     = r_idx + CW'(1);
                    n_p_valid = 1'b1;
                    n_p_voice = r_idx[VW-1:0];
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_res_sample;
                    n_out_status = r_res_status;
                    n_out_count  = COUNT_O_W'(r_snd_cnt);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p_valid   <= 1'b0;
            r_idx       <= '0;
            r_active    <= '0;
            r_free_cnt  <= CW'(VOICES);
            r_snd_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p_valid   <= n_p_valid;
            r_idx       <= n_idx;
            r_active    <= n_active;
            r_free_cnt  <= n_free_cnt;
            r_snd_cnt   <= n_snd_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_inc        <= n_inc;
        r_p_voice    <= n_p_voice;
        r_sum        <= n_sum;
        r_res_sample <= n_res_sample;
        r_res_status <= n_res_status;
        r_out_sample <= n_out_sample;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.sample        = r_out_sample;
    assign o_res.status        = r_out_status;
    assign o_res.active_voices = r_out_count;

endmodule

// File: hdl/ptvm_checker.sv
`timescale 1ns / 1ps

module ptvm_checker #(
    parameter int unsigned VOICES = ptvm_pkg::VOICES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input ptvm_pkg::t_sample  i_sample,
    input ptvm_pkg::t_status  i_status,
    input ptvm_pkg::t_count_o i_active_voices
);
    import ptvm_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // the voice count never passes the pool size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_active_voices <= COUNT_O_W'(VOICES))
        else $error("sounding count above voice pool");

    // a refused note on only happens with every voice sounding
    a_full_on_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status == ST_NO_FREE |-> i_active_voices == COUNT_O_W'(VOICES))
        else $error("no free voice reported with voices left");

    // a failed request carries a silent sample
    a_silent_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status != ST_OK |-> i_sample == '0)
        else $error("nonzero sample on failed request");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_sample)
            && $stable(i_status) && $stable(i_active_voices))
        else $error("stalled result changed");

endmodule

bind polyphonic_triangle_voice_mixer ptvm_checker #(.VOICES(VOICES)) u_ptvm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_sample        (o_res.sample),
    .i_status        (o_res.status),
    .i_active_voices (o_res.active_voices)
);
